// ===== rtl/core/max_heap_delete_by_key_top_defines.svh =====
// ----------------------------------------------------------------------------
// max_heap_delete_by_key_top_defines
// assertion macros shared by the heap block
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_DELETE_BY_KEY_TOP_DEFINES_SVH
`define MAX_HEAP_DELETE_BY_KEY_TOP_DEFINES_SVH

// same-cycle implication
`define MHDK_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mhdk assertion failed");

// next-cycle implication
`define MHDK_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mhdk assertion failed");

`endif

// ===== rtl/core/mhdk_pkg.sv =====
// ----------------------------------------------------------------------------
// mhdk_pkg
// types and constants shared by the heap controller, datapath and top level
// ----------------------------------------------------------------------------
package mhdk_pkg;

	localparam int HEAP_DEPTH = 32;
	localparam int MAX_OUT    = 32;
	localparam int VAL_W      = 32;
	localparam int POS_W      = 5;
	localparam int AW         = $clog2(HEAP_DEPTH);
	localparam int CW         = $clog2(HEAP_DEPTH + 1);
	localparam int LW         = AW + 2;
	localparam int EXW        = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam int TDATA_W    = 40;
	localparam int TUSER_W    = 3;

	typedef enum logic {
		CMD_APPEND = 1'b0,
		CMD_DELETE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_APPEND_OK = 2'd0,
		KIND_FULL      = 2'd1,
		KIND_ENTRY     = 2'd2,
		KIND_EMPTY     = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_APPEND,
		OP_SCAN,
		OP_HIT,
		OP_LOAD,
		OP_UP_RD,
		OP_UP_MOVE,
		OP_PUT,
		OP_DN_RDL,
		OP_DN_L,
		OP_DN_R,
		OP_DN_MOVE,
		OP_EMPTY,
		OP_EMIT_START,
		OP_EMIT
	} op_t;

	typedef struct packed {
		logic full;
		logic cnt_zero;
		logic hit;
		logic miss;
		logic last_slot;
		logic i_zero;
		logic up_gt;
		logic moved;
		logic l_out;
		logic r_in;
		logic big_self;
		logic out_free;
		logic emit_last;
	} sts_t;

endpackage

// ===== rtl/core/mhdk_ram.sv =====
// ----------------------------------------------------------------------------
// mhdk_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module mhdk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/mhdk_datapath.sv =====
// ----------------------------------------------------------------------------
// mhdk_datapath
// heap storage, scan, sift and emit registers, result output register
// ----------------------------------------------------------------------------
module mhdk_datapath import mhdk_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  op_t                op,
	input  logic [VAL_W-1:0]   key_in,
	input  logic               m_tready,
	output sts_t               sts,
	output logic               m_tvalid,
	output logic [TDATA_W-1:0] m_tdata,
	output logic [TUSER_W-1:0] m_tuser,
	output logic               m_tlast
);

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [VAL_W-1:0] ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [VAL_W-1:0] ram_rdata;

	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    cnt_m1;
	logic [VAL_W-1:0] key_q;
	logic             found_q;
	logic [CW-1:0]    scan_q;
	logic             chk_vld_s1;
	logic [AW-1:0]    idx_s1;
	logic [AW-1:0]    idx_q;
	logic [VAL_W-1:0] v_q;
	logic [AW-1:0]    i_q;
	logic             moved_q;
	logic [VAL_W-1:0] big_q;
	logic [AW-1:0]    bigidx_q;
	logic [POS_W-1:0] e_q;

	logic [AW-1:0]    par;
	logic [LW-1:0]    l_w;
	logic [LW-1:0]    r_w;
	logic             match;

	logic             out_load;
	kind_t            out_kind_d;
	logic [VAL_W-1:0] out_val_d;
	logic [POS_W-1:0] out_pos_d;
	logic             out_found_d;
	logic             out_last_d;

	logic             out_vld_q;
	kind_t            out_kind_q;
	logic [VAL_W-1:0] out_val_q;
	logic [POS_W-1:0] out_pos_q;
	logic             out_found_q;
	logic             out_last_q;

	mhdk_ram #(
		.WIDTH (VAL_W),
		.DEPTH (HEAP_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cnt_m1 = cnt_q - CW'(1);
	assign par    = (i_q - AW'(1)) >> 1;
	assign l_w    = {1'b0, i_q, 1'b1};
	assign r_w    = l_w + LW'(1);
	assign match  = (ram_rdata == key_q);

	assign sts.full      = (cnt_q >= CW'(HEAP_DEPTH));
	assign sts.cnt_zero  = (cnt_q == '0);
	assign sts.hit       = chk_vld_s1 && match;
	assign sts.miss      = (cnt_q == '0) ||
	                       (chk_vld_s1 && !match && (CW'(idx_s1) == cnt_m1));
	assign sts.last_slot = (CW'(idx_q) == cnt_m1);
	assign sts.i_zero    = (i_q == '0);
	assign sts.up_gt     = ($signed(v_q) > $signed(ram_rdata));
	assign sts.moved     = moved_q;
	assign sts.l_out     = (l_w >= LW'(cnt_q));
	assign sts.r_in      = (r_w < LW'(cnt_q));
	assign sts.big_self  = (bigidx_q == i_q);
	assign sts.out_free  = !out_vld_q || m_tready;
	assign sts.emit_last = ((EXW'(e_q) + EXW'(1)) == EXW'(cnt_q)) ||
	                       (e_q == POS_W'(MAX_OUT - 1));

	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = i_q;
		ram_wdata   = v_q;
		ram_re      = 1'b0;
		ram_raddr   = AW'(scan_q);
		out_load    = 1'b0;
		out_kind_d  = KIND_ENTRY;
		out_val_d   = '0;
		out_pos_d   = '0;
		out_found_d = found_q;
		out_last_d  = 1'b1;
		unique case (op)
			OP_APPEND: begin
				out_load    = 1'b1;
				out_found_d = 1'b0;
				if (sts.full) begin
					out_kind_d = KIND_FULL;
				end else begin
					out_kind_d = KIND_APPEND_OK;
					ram_we     = 1'b1;
					ram_waddr  = AW'(cnt_q);
					ram_wdata  = key_q;
				end
			end
			OP_SCAN: begin
				ram_re = 1'b1;
			end
			OP_HIT: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(cnt_m1);
			end
			OP_UP_RD: begin
				ram_re    = 1'b1;
				ram_raddr = par;
			end
			OP_UP_MOVE: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			OP_PUT: begin
				ram_we = 1'b1;
			end
			OP_DN_RDL: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(l_w);
			end
			OP_DN_L: begin
				ram_re    = sts.r_in;
				ram_raddr = AW'(r_w);
			end
			OP_DN_MOVE: begin
				ram_we    = 1'b1;
				ram_wdata = big_q;
			end
			OP_EMPTY: begin
				out_load   = 1'b1;
				out_kind_d = KIND_EMPTY;
			end
			OP_EMIT_START: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
			end
			OP_EMIT: begin
				out_load   = 1'b1;
				out_kind_d = KIND_ENTRY;
				out_val_d  = ram_rdata;
				out_pos_d  = e_q;
				out_last_d = sts.emit_last;
				ram_re     = 1'b1;
				ram_raddr  = AW'(e_q + POS_W'(1));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			chk_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (op == OP_APPEND && !sts.full) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (op == OP_HIT) begin
				cnt_q <= cnt_m1;
			end
			if (op == OP_SCAN) begin
				chk_vld_s1 <= (scan_q < cnt_q);
			end else begin
				chk_vld_s1 <= 1'b0;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_ACCEPT: begin
				key_q   <= key_in;
				scan_q  <= '0;
				found_q <= 1'b0;
			end
			OP_SCAN: begin
				idx_s1 <= AW'(scan_q);
				if (scan_q < cnt_q) begin
					scan_q <= scan_q + CW'(1);
				end
				if (sts.hit) begin
					idx_q <= idx_s1;
				end
			end
			OP_HIT: begin
				found_q <= 1'b1;
			end
			OP_LOAD: begin
				v_q     <= ram_rdata;
				i_q     <= idx_q;
				moved_q <= 1'b0;
			end
			OP_UP_MOVE: begin
				i_q     <= par;
				moved_q <= 1'b1;
			end
			OP_DN_L: begin
				if ($signed(ram_rdata) > $signed(v_q)) begin
					big_q    <= ram_rdata;
					bigidx_q <= AW'(l_w);
				end else begin
					big_q    <= v_q;
					bigidx_q <= i_q;
				end
			end
			OP_DN_R: begin
				if ($signed(ram_rdata) > $signed(big_q)) begin
					big_q    <= ram_rdata;
					bigidx_q <= AW'(r_w);
				end
			end
			OP_DN_MOVE: begin
				i_q <= bigidx_q;
			end
			OP_EMIT_START: begin
				e_q <= '0;
			end
			OP_EMIT: begin
				e_q <= e_q + POS_W'(1);
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_kind_q  <= out_kind_d;
			out_val_q   <= out_val_d;
			out_pos_q   <= out_pos_d;
			out_found_q <= out_found_d;
			out_last_q  <= out_last_d;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {(TDATA_W - VAL_W - POS_W)'(0), out_pos_q, out_val_q};
	assign m_tuser  = {out_found_q, out_kind_q};
	assign m_tlast  = out_last_q;

endmodule

// ===== rtl/core/mhdk_ctrl.sv =====
// ----------------------------------------------------------------------------
// mhdk_ctrl
// sequencer for append, key scan, sift up, sift down and emit
// ----------------------------------------------------------------------------
module mhdk_ctrl import mhdk_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  cmd_t cmd,
	input  sts_t sts,
	output logic s_tready,
	output op_t  op
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_APPEND,
		ST_SCAN,
		ST_HIT,
		ST_LOAD,
		ST_UP_A,
		ST_UP_B,
		ST_DN_L,
		ST_DN_R,
		ST_DN_C,
		ST_DN_D,
		ST_EMIT_RD,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   ready_q;

	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && ready_q) begin
					op      = OP_ACCEPT;
					state_d = (cmd == CMD_APPEND) ? ST_APPEND : ST_SCAN;
				end
			end
			ST_APPEND: begin
				if (sts.out_free) begin
					op      = OP_APPEND;
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				op = OP_SCAN;
				if (sts.hit) begin
					state_d = ST_HIT;
				end else if (sts.miss) begin
					state_d = ST_EMIT_RD;
				end
			end
			ST_HIT: begin
				op      = OP_HIT;
				state_d = sts.last_slot ? ST_EMIT_RD : ST_LOAD;
			end
			ST_LOAD: begin
				op      = OP_LOAD;
				state_d = ST_UP_A;
			end
			ST_UP_A: begin
				if (!sts.i_zero) begin
					op      = OP_UP_RD;
					state_d = ST_UP_B;
				end else if (sts.moved) begin
					op      = OP_PUT;
					state_d = ST_EMIT_RD;
				end else begin
					state_d = ST_DN_L;
				end
			end
			ST_UP_B: begin
				if (sts.up_gt) begin
					op      = OP_UP_MOVE;
					state_d = ST_UP_A;
				end else if (sts.moved) begin
					op      = OP_PUT;
					state_d = ST_EMIT_RD;
				end else begin
					state_d = ST_DN_L;
				end
			end
			ST_DN_L: begin
				if (sts.l_out) begin
					op      = OP_PUT;
					state_d = ST_EMIT_RD;
				end else begin
					op      = OP_DN_RDL;
					state_d = ST_DN_R;
				end
			end
			ST_DN_R: begin
				op      = OP_DN_L;
				state_d = sts.r_in ? ST_DN_C : ST_DN_D;
			end
			ST_DN_C: begin
				op      = OP_DN_R;
				state_d = ST_DN_D;
			end
			ST_DN_D: begin
				if (sts.big_self) begin
					op      = OP_PUT;
					state_d = ST_EMIT_RD;
				end else begin
					op      = OP_DN_MOVE;
					state_d = ST_DN_L;
				end
			end
			ST_EMIT_RD: begin
				if (!sts.cnt_zero) begin
					op      = OP_EMIT_START;
					state_d = ST_EMIT;
				end else if (sts.out_free) begin
					op      = OP_EMPTY;
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					op = OP_EMIT;
					if (sts.emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == ST_IDLE);
		end
	end

	assign s_tready = ready_q;

endmodule

// ===== rtl/core/max_heap_delete_by_key_top.sv =====
// ----------------------------------------------------------------------------
// max_heap_delete_by_key_top
// binary max-heap with append and delete by key, contents streamed after delete
//
// channel  dir  tdata                          tuser               tlast
// s_*      in   value[31:0]                    cmd[0]              -
// m_*      out  entry_value[31:0] pos[36:32]   kind[1:0] found[2]  last
//
// append: one result
// delete: key scan and sift through the single ram read port,
// then one result per cycle while m_tready holds, at most 32 results per request
// reset clears the entry count and the output valid, no ram clearing pass
// the result register lets the final result wait while the next request enters
// ----------------------------------------------------------------------------
`include "max_heap_delete_by_key_top_defines.svh"

module max_heap_delete_by_key_top import mhdk_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [VAL_W-1:0]   s_tdata,   // value
	input  logic [0:0]         s_tuser,   // cmd
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // entry_value, position, zero pad
	output logic [TUSER_W-1:0] m_tuser,   // kind, found
	output logic               m_tlast
);

	op_t   op;
	sts_t  sts;
	cmd_t  cmd;
	kind_t m_kind;
	logic  m_append;

	assign cmd = cmd_t'(s_tuser[0]);

	mhdk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.cmd      (cmd),
		.sts      (sts),
		.s_tready (s_tready),
		.op       (op)
	);

	mhdk_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.key_in   (s_tdata),
		.m_tready (m_tready),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	assign m_kind   = kind_t'(m_tuser[1:0]);
	assign m_append = (m_kind == KIND_APPEND_OK) || (m_kind == KIND_FULL);

	// one request at a time
	`MHDK_ASSERT_NXT(a_one_request, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// only heap entries carry data
	`MHDK_ASSERT_IMP(a_data_zero, clk, arst_n, m_tvalid && (m_kind != KIND_ENTRY), m_tdata == '0)

	// append results never report a removed key and always carry tlast
	`MHDK_ASSERT_IMP(a_append_found, clk, arst_n, m_tvalid && m_append, !m_tuser[2] && m_tlast)

endmodule
